/* design/ptd_pkg.sv */
// ptd_pkg: shared types and constants of the priority task deque
// command codes, select and result enums, datapath command and status structs, default depth
// no dependencies
`default_nettype none

package ptd_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_POP   = 3'd1;
  localparam logic [2:0] CMD_DEL   = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_NEWID = 3'd4;

  // write address select
  typedef enum logic [1:0] {
    WR_HEAD_DEC,
    WR_TAIL,
    WR_SHIFT
  } wr_sel_e;

  // read address select, relative to head
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT1,
    RD_NEXT2
  } rd_sel_e;

  // what the result registers load
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_OK,
    RES_POP,
    RES_NEWID
  } res_kind_e;

  typedef struct packed {
    logic      load_key;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      wr_from_rd;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      head_dec;
    logic      head_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      idx_clr;
    logic      idx_inc;
    logic      id_inc;
    logic      res_valid;
    res_kind_e res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/ptd_ctrl.sv */
// ptd_ctrl: controller state machine of the priority task deque
// decodes commands and sequences pop, delete scan and compaction
// depends on ptd_pkg
`default_nettype none

module ptd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2:0]          cmd_i,
  input  wire logic                high_priority_i,
  input  wire ptd_pkg::dp_status_t status_i,
  output ptd_pkg::dp_cmd_t         cmd_o,
  output logic                     busy_o
);
  import ptd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_POP   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_ADD: begin
              cmd_o.res_valid = 1'b1;
              if (status_i.full) begin
                cmd_o.res_kind = RES_FAIL;
              end else begin
                cmd_o.wr_en    = 1'b1;
                cmd_o.wr_sel   = high_priority_i ? WR_HEAD_DEC : WR_TAIL;
                cmd_o.head_dec = high_priority_i;
                cmd_o.cnt_inc  = 1'b1;
                cmd_o.res_kind = RES_OK;
              end
            end
            CMD_POP: begin
              if (status_i.empty) begin
                cmd_o.res_valid = 1'b1;
                cmd_o.res_kind  = RES_FAIL;
              end else begin
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_sel   = RD_HEAD;
                cmd_o.head_inc = 1'b1;
                cmd_o.cnt_dec  = 1'b1;
                state_d        = ST_POP;
              end
            end
            CMD_DEL: begin
              if (status_i.empty) begin
                cmd_o.res_valid = 1'b1;
                cmd_o.res_kind  = RES_FAIL;
              end else begin
                cmd_o.load_key = 1'b1;
                cmd_o.idx_clr  = 1'b1;
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_sel   = RD_HEAD;
                state_d        = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              cmd_o.cnt_clr   = 1'b1;
              cmd_o.res_valid = 1'b1;
              cmd_o.res_kind  = RES_OK;
            end
            CMD_NEWID: begin
              cmd_o.id_inc    = 1'b1;
              cmd_o.res_valid = 1'b1;
              cmd_o.res_kind  = RES_NEWID;
            end
            default: begin
              cmd_o.res_valid = 1'b1;
              cmd_o.res_kind  = RES_FAIL;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd_o.res_valid = 1'b1;
        cmd_o.res_kind  = RES_POP;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        // read data holds the entry at idx, fetch idx+1 ahead
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_NEXT1;
        if (status_i.match) begin
          state_d = ST_SHIFT;
        end else if (status_i.last) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_kind  = RES_FAIL;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SHIFT: begin
        // read data holds the entry at idx+1, move it down to idx
        if (status_i.last) begin
          cmd_o.cnt_dec   = 1'b1;
          cmd_o.res_valid = 1'b1;
          cmd_o.res_kind  = RES_OK;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_SHIFT;
          cmd_o.wr_from_rd = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel     = RD_NEXT2;
          cmd_o.idx_inc    = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ptd_dp.sv */
// ptd_dp: datapath of the priority task deque
// circular entry memory, head pointer, fill count, scan index, id counter, result registers
// depends on ptd_pkg
`default_nettype none

module ptd_dp #(
  parameter int unsigned QUEUE_DEPTH = ptd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ptd_pkg::dp_cmd_t cmd_i,
  input  wire logic [31:0]      task_handle_i,
  input  wire logic [31:0]      task_id_i,
  input  wire logic             high_priority_i,
  output ptd_pkg::dp_status_t   status_o,
  output logic                  done_o,
  output logic                  ok_o,
  output logic [31:0]           out_handle_o,
  output logic [31:0]           out_id_o,
  output logic                  out_high_o
);
  import ptd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] id;
    logic        high;
  } entry_t;

  // logical position relative to head, wrapped into the circular buffer
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + off;
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] idx_q, idx_d;
  logic [31:0]      key_q;
  logic [31:0]      id_q, id_next;
  logic             done_q;
  logic             ok_q, out_high_q;
  logic [31:0]      out_handle_q, out_id_q;

  logic [PTR_W-1:0] head_m1, head_p1;
  logic [SUM_W-1:0] off_next1, off_next2, rd_off;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic             rd_fire;
  entry_t           wr_data;

  assign head_m1 = (head_q == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_q - PTR_W'(1);
  assign head_p1 = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  assign off_next1 = SUM_W'(idx_q) + SUM_W'(1);
  assign off_next2 = SUM_W'(idx_q) + SUM_W'(2);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD:  rd_off = '0;
      RD_NEXT1: rd_off = off_next1;
      RD_NEXT2: rd_off = off_next2;
      default:  rd_off = '0;
    endcase
  end

  // no fetch past the last stored entry
  assign rd_fire = cmd_i.rd_en && (rd_off < SUM_W'(cnt_q));
  assign rd_addr = phys(head_q, rd_off);

  always_comb begin
    case (cmd_i.wr_sel)
      WR_HEAD_DEC: wr_addr = head_m1;
      WR_TAIL:     wr_addr = phys(head_q, SUM_W'(cnt_q));
      WR_SHIFT:    wr_addr = phys(head_q, SUM_W'(idx_q));
      default:     wr_addr = head_q;
    endcase
  end

  always_comb begin
    if (cmd_i.wr_from_rd) begin
      wr_data = rd_q;
    end else begin
      wr_data.handle = task_handle_i;
      wr_data.id     = task_id_i;
      wr_data.high   = high_priority_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_fire) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = head_m1;
    end else if (cmd_i.head_inc) begin
      head_d = head_p1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + PTR_W'(1);
    end
  end

  // counter skips zero on wrap
  assign id_next = (id_q == 32'hFFFF_FFFF) ? 32'd1 : id_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
      id_q   <= '0;
      done_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      done_q <= cmd_i.res_valid;
      if (cmd_i.id_inc) begin
        id_q <= id_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= task_id_i;
    end
    if (cmd_i.res_valid) begin
      case (cmd_i.res_kind)
        RES_FAIL: begin
          ok_q         <= 1'b0;
          out_handle_q <= '0;
          out_id_q     <= '0;
          out_high_q   <= 1'b0;
        end
        RES_OK: begin
          ok_q         <= 1'b1;
          out_handle_q <= '0;
          out_id_q     <= '0;
          out_high_q   <= 1'b0;
        end
        RES_POP: begin
          ok_q         <= 1'b1;
          out_handle_q <= rd_q.handle;
          out_id_q     <= rd_q.id;
          out_high_q   <= rd_q.high;
        end
        RES_NEWID: begin
          ok_q         <= 1'b1;
          out_handle_q <= '0;
          out_id_q     <= id_next;
          out_high_q   <= 1'b0;
        end
        default: begin
          ok_q         <= 1'b0;
          out_handle_q <= '0;
          out_id_q     <= '0;
          out_high_q   <= 1'b0;
        end
      endcase
    end
  end

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.match = (rd_q.id == key_q);
  assign status_o.last  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign out_handle_o = out_handle_q;
  assign out_id_o     = out_id_q;
  assign out_high_o   = out_high_q;

endmodule

`default_nettype wire

/* design/priority_task_deque.sv */
// Task deque of QUEUE_DEPTH entries (handle, id, priority mark) held in a circular
// memory. A command is taken when start_i is high and busy_o is low; its single
// result appears on the result ports for one cycle with done_o high and must be
// taken then, there is no way to hold it off. Add, clear, new id and each command
// that fails when taken give their result in the cycle after and leave busy_o low,
// so one such command may follow each cycle. Pop reads the head entry through the
// registered memory read, then loads the result. Delete scans from the head one
// entry a cycle through the same read port, then moves each later entry down one
// place a cycle. No clearing pass after reset.
// depends on ptd_pkg, ptd_ctrl, ptd_dp
`default_nettype none

module priority_task_deque #(
  parameter int unsigned QUEUE_DEPTH = ptd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] task_handle_i,
  input  wire logic [31:0] task_id_i,
  input  wire logic        high_priority_i,
  output logic             done_o,
  output logic             ok_o,
  output logic [31:0]      out_handle_o,
  output logic [31:0]      out_id_o,
  output logic             out_high_o
);
  import ptd_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ptd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .cmd_i           (cmd_i),
    .high_priority_i (high_priority_i),
    .status_i        (dp_status),
    .cmd_o           (dp_cmd),
    .busy_o          (busy_o)
  );

  ptd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .task_handle_i   (task_handle_i),
    .task_id_i       (task_id_i),
    .high_priority_i (high_priority_i),
    .status_o        (dp_status),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .out_handle_o    (out_handle_o),
    .out_id_o        (out_id_o),
    .out_high_o      (out_high_o)
  );

endmodule

`default_nettype wire
